/* design/b2da_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary to decimal ASCII package
// Shared constants, types and helper function of the converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

    localparam int DEF_VALUE_WIDTH = 32;
    localparam int DEF_MAX_DIGITS  = 10;
    localparam int FIXED_DIGITS    = 4;
    localparam int ASCII_W         = 6;
    localparam int DIGIT_W         = 4;

    localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'd48;

    typedef logic [DIGIT_W-1:0] t_digit;

    typedef struct packed {
        logic load;
        logic shift;
    } t_dp_cmd;

    typedef struct packed {
        logic digit_zero;
        logic upper_nz;
    } t_dp_status;

    function automatic t_digit add3(input t_digit d);
        t_digit r;
        if (d >= t_digit'(5)) begin
            r = d + t_digit'(3);
        end else begin
            r = d;
        end
        return r;
    endfunction

endpackage

/* design/b2da_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary to decimal ASCII datapath
// Shift-add-3 conversion registers and the digit select for the output.
// ----------------------------------------------------------------------------
module b2da_datapath #(
    parameter int VALUE_WIDTH = b2da_pkg::DEF_VALUE_WIDTH,
    parameter int MAX_DIGITS  = b2da_pkg::DEF_MAX_DIGITS
) (
    input  logic                              i_clk,
    input  logic [VALUE_WIDTH-1:0]            i_value,
    input  b2da_pkg::t_dp_cmd                 i_cmd,
    input  logic [$clog2(MAX_DIGITS)-1:0]     i_idx,
    output b2da_pkg::t_dp_status              o_status,
    output logic [b2da_pkg::ASCII_W-1:0]      o_ascii_digit
);
    import b2da_pkg::*;

    localparam int NEED_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int EXT_DIGITS  = (NEED_DIGITS > MAX_DIGITS) ? NEED_DIGITS : MAX_DIGITS;
    localparam int BCD_DIGITS  = EXT_DIGITS + 1;
    localparam int BCD_W       = BCD_DIGITS * DIGIT_W;

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;
    logic [BCD_W-1:0]       r_bcd;
    logic [BCD_W-1:0]       n_bcd;
    logic [BCD_W-1:0]       w_adj;
    t_digit                 w_low [MAX_DIGITS];
    t_digit                 w_sel;

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            w_adj[i*DIGIT_W +: DIGIT_W] = add3(r_bcd[i*DIGIT_W +: DIGIT_W]);
        end
    end

    always_comb begin
        n_value = r_value;
        n_bcd   = r_bcd;
        if (i_cmd.load) begin
            n_value = i_value;
            n_bcd   = '0;
        end else if (i_cmd.shift) begin
            n_value = {r_value[VALUE_WIDTH-2:0], 1'b0};
            n_bcd   = {w_adj[BCD_W-2:0], r_value[VALUE_WIDTH-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_bcd   <= n_bcd;
    end

    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            w_low[i] = r_bcd[i*DIGIT_W +: DIGIT_W];
        end
    end

    assign w_sel               = w_low[i_idx];
    assign o_status.digit_zero = (w_sel == '0);
    assign o_status.upper_nz   = |r_bcd[BCD_W-1:MAX_DIGITS*DIGIT_W];
    assign o_ascii_digit       = ASCII_ZERO + {{(ASCII_W-DIGIT_W){1'b0}}, w_sel};

endmodule

/* design/b2da_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary to decimal ASCII controller
// Sequences load, conversion and digit emission, and holds the mode register.
// ----------------------------------------------------------------------------
module b2da_ctrl #(
    parameter int VALUE_WIDTH = b2da_pkg::DEF_VALUE_WIDTH,
    parameter int MAX_DIGITS  = b2da_pkg::DEF_MAX_DIGITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_last_digit,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,
    output b2da_pkg::t_dp_cmd             o_cmd,
    output logic [$clog2(MAX_DIGITS)-1:0] o_idx,
    input  b2da_pkg::t_dp_status          i_status
);
    import b2da_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam int IDX_W = $clog2(MAX_DIGITS);

    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(VALUE_WIDTH - 1);
    localparam logic [IDX_W-1:0] VAR_START = IDX_W'(MAX_DIGITS - 1);
    localparam logic [IDX_W-1:0] FIX_START = IDX_W'(FIXED_DIGITS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             r_started;
    logic             n_started;
    logic             r_mode;
    logic             w_skip;

    assign o_cfg_ready  = 1'b1;
    assign o_stall      = (r_state != ST_IDLE);
    assign o_idx        = r_idx;
    assign o_last_digit = (r_idx == '0);

    assign w_skip = !r_mode && !r_started && i_status.digit_zero
                    && (r_idx != '0) && !i_status.upper_nz;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_started   = r_started;
        o_cmd.load  = 1'b0;
        o_cmd.shift = 1'b0;
        o_valid     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = CNT_LAST;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.shift = 1'b1;
                if (r_cnt == '0) begin
                    n_state   = ST_EMIT;
                    n_started = 1'b0;
                    n_idx     = r_mode ? FIX_START : VAR_START;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_EMIT: begin
                o_valid = !w_skip;
                if (w_skip) begin
                    n_idx = r_idx - 1'b1;
                end else if (!i_stall) begin
                    n_started = 1'b1;
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_started <= 1'b0;
            r_mode    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_idx     <= n_idx;
            r_started <= n_started;
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
        end
    end

endmodule

/* design/binary_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary to decimal ASCII converter
// Converts an unsigned value to ASCII decimal digits, most significant first.
//
// Channel   Direction  Handshake              Payload
// input     in         i_valid / o_stall      i_value
// output    out        o_valid / i_stall      o_ascii_digit, o_last_digit
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (digit mode)
//
// After the accept beat an item runs through the shift-add-3 loop, one shift
// per value bit, then steps from the top digit position down: MAX_DIGITS
// positions in variable mode, where leading zeros are skipped, and four in
// fixed mode. No new item is accepted until its last digit has been taken.
// Reset is synchronous and clears the controller and the mode to variable.
// A stall on the output holds the current digit beat.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = b2da_pkg::DEF_VALUE_WIDTH,
    parameter int MAX_DIGITS  = b2da_pkg::DEF_MAX_DIGITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [VALUE_WIDTH-1:0]           i_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [b2da_pkg::ASCII_W-1:0]     o_ascii_digit,
    output logic                             o_last_digit,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_data
);
    import b2da_pkg::*;

    t_dp_cmd                       w_cmd;
    t_dp_status                    w_status;
    logic [$clog2(MAX_DIGITS)-1:0] w_idx;

    b2da_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_last_digit (o_last_digit),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_cmd        (w_cmd),
        .o_idx        (w_idx),
        .i_status     (w_status)
    );

    b2da_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_value       (i_value),
        .i_cmd         (w_cmd),
        .i_idx         (w_idx),
        .o_status      (w_status),
        .o_ascii_digit (o_ascii_digit)
    );

endmodule
